// ----- hw/rtl/blbm_pkg.sv -----
// Shared types and constants of the band level bar meter.
package blbm_pkg;

    localparam int BAND_W      = 3;
    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 8;
    localparam int COUNT_W     = 3;
    localparam int PATTERN_W   = 6;
    localparam int BOUND_W     = 10;

    localparam int HISTORY_TAPS = 4;
    localparam int TAP_SHIFT    = $clog2(HISTORY_TAPS);
    localparam int SUM_W        = LEVEL_W + TAP_SHIFT;
    localparam int NUM_BARS     = 6;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [BAND_W-1:0] FIRST_BAND     = 3'd0;
    localparam logic [BAND_W-1:0] TOPDOWN_BAND_A = 3'd3;
    localparam logic [BAND_W-1:0] TOPDOWN_BAND_B = 3'd4;
    localparam logic [BAND_W-1:0] UNLIT_BAND     = 3'd6;

    typedef enum logic [2:0] {
        REG_SENSITIVITY = 3'd0,
        REG_FIRST_FLOOR = 3'd1,
        REG_BAND_FLOOR  = 3'd2,
        REG_THR_BASE    = 3'd3,
        REG_THR_STEP    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] sensitivity;
        logic [7:0] first_band_floor;
        logic [7:0] band_floor;
        logic [7:0] threshold_base;
        logic [5:0] threshold_step;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sensitivity:      7'd0,
        first_band_floor: 8'd50,
        band_floor:       8'd100,
        threshold_base:   8'd100,
        threshold_step:   6'd10
    };

    typedef logic [HISTORY_TAPS-1:0][LEVEL_W-1:0] t_row;

endpackage

// ----- hw/rtl/blbm_grader.sv -----
// Threshold table and bar grading of the band level bar meter.
module blbm_grader (
    input  logic                              i_clk,
    input  blbm_pkg::t_cfg                    i_cfg,
    input  logic [blbm_pkg::BAND_W-1:0]       i_band,
    input  logic [blbm_pkg::LEVEL_W-1:0]      i_level,
    output logic [blbm_pkg::COUNT_W-1:0]      o_count,
    output logic [blbm_pkg::PATTERN_W-1:0]    o_pattern
);

    // Thresholds 1 .. NUM_BARS-1, refreshed from the registers every cycle.
    logic [blbm_pkg::BOUND_W-1:0] r_thr [blbm_pkg::NUM_BARS-1];
    logic [blbm_pkg::BOUND_W-1:0] w_bnd [blbm_pkg::NUM_BARS+1];
    logic [blbm_pkg::COUNT_W-1:0] w_count;
    logic [blbm_pkg::NUM_BARS-1:0] w_low_up;
    logic [blbm_pkg::NUM_BARS-1:0] w_top_down;
    logic                          w_top;

    always_ff @(posedge i_clk) begin
        for (int k = 1; k < blbm_pkg::NUM_BARS; k++) begin
            r_thr[k-1] <= blbm_pkg::BOUND_W'(i_cfg.threshold_base)
                        + blbm_pkg::BOUND_W'(i_cfg.threshold_step)
                          * blbm_pkg::BOUND_W'(k)
                        + blbm_pkg::BOUND_W'(i_cfg.sensitivity);
        end
    end

    // Bound 0 is the floor, the last bound lies above any level.
    always_comb begin
        if (i_band == blbm_pkg::FIRST_BAND) begin
            w_bnd[0] = blbm_pkg::BOUND_W'(i_cfg.first_band_floor);
        end else begin
            w_bnd[0] = blbm_pkg::BOUND_W'(i_cfg.band_floor);
        end
        for (int k = 1; k < blbm_pkg::NUM_BARS; k++) begin
            w_bnd[k] = r_thr[k-1];
        end
        w_bnd[blbm_pkg::NUM_BARS] = '1;
    end

    // Lowest window that holds the level wins.
    always_comb begin
        w_count = '0;
        for (int j = blbm_pkg::NUM_BARS; j >= 1; j--) begin
            if ((blbm_pkg::BOUND_W'(i_level) > w_bnd[j-1]) &&
                (blbm_pkg::BOUND_W'(i_level) <= w_bnd[j])) begin
                w_count = blbm_pkg::COUNT_W'(j);
            end
        end
        if (i_band == blbm_pkg::UNLIT_BAND) begin
            w_count = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < blbm_pkg::NUM_BARS; i++) begin
            w_low_up[i]   = (i < int'(w_count));
            w_top_down[i] = ((i + int'(w_count)) >= blbm_pkg::NUM_BARS);
        end
    end

    assign w_top = (i_band == blbm_pkg::TOPDOWN_BAND_A) ||
                   (i_band == blbm_pkg::TOPDOWN_BAND_B);

    assign o_count   = w_count;
    assign o_pattern = blbm_pkg::PATTERN_W'(w_top ? w_top_down : w_low_up);

endmodule

// ----- hw/rtl/band_level_bar_meter.sv -----
// Top level of the band level bar meter: history, averaging and output stage.
//
// Usage: each slave beat carries one converter reading (s_axis_tdata[9:0])
// for one spectrum band (s_axis_tuser). The reading's upper eight bits are
// shifted into that band's four-entry history, the history is averaged, and
// the average is graded into 0 to 6 bars against a floor and five thresholds
// set over the APB port. Every slave beat yields exactly one master beat with
// the band, the level, the bar count and the six-bit bar pattern.
// Stages from slave beat to master beat, each registered: history update,
// four-tap sum, grade into the output register.
// Throughput: one beat per cycle while the receiver does not stall; the
// history row is read, shifted and written back in the accept cycle, so beats
// of the same band may follow one another without a gap.
// Reset clears all band histories at once and loads the register defaults;
// the block takes beats as soon as reset is released.
// Receiver stall: the output register holds its beat; the stages behind it
// keep filling empty slots, and s_axis_tready falls only once every stage
// holds a beat. Nothing is dropped or repeated.
// Bands at or above NUM_BANDS touch no history and give all-zero results.
module band_level_bar_meter #(
    parameter int NUM_BANDS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [blbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [9:0] sample
    input  logic [blbm_pkg::BAND_W-1:0]         s_axis_tuser,  // [2:0] band
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] averaged_level, [10:8] bar_count, [16:11] bar_pattern
    output logic [blbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [blbm_pkg::BAND_W-1:0]         m_axis_tuser,  // [2:0] band_out
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [blbm_pkg::PADDR_W-1:0]        paddr,
    input  logic [blbm_pkg::PDATA_W-1:0]        pwdata,
    output logic [blbm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [4:0] NUM_BANDS_V = 5'(NUM_BANDS);

    // ---------------- configuration registers ----------------
    blbm_pkg::t_cfg       r_cfg;
    blbm_pkg::t_reg_idx   w_reg;

    assign pready = 1'b1;
    assign w_reg  = blbm_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= blbm_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                blbm_pkg::REG_SENSITIVITY: r_cfg.sensitivity      <= pwdata[6:0];
                blbm_pkg::REG_FIRST_FLOOR: r_cfg.first_band_floor <= pwdata[7:0];
                blbm_pkg::REG_BAND_FLOOR:  r_cfg.band_floor       <= pwdata[7:0];
                blbm_pkg::REG_THR_BASE:    r_cfg.threshold_base   <= pwdata[7:0];
                blbm_pkg::REG_THR_STEP:    r_cfg.threshold_step   <= pwdata[5:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            blbm_pkg::REG_SENSITIVITY: prdata = 32'(r_cfg.sensitivity);
            blbm_pkg::REG_FIRST_FLOOR: prdata = 32'(r_cfg.first_band_floor);
            blbm_pkg::REG_BAND_FLOOR:  prdata = 32'(r_cfg.band_floor);
            blbm_pkg::REG_THR_BASE:    prdata = 32'(r_cfg.threshold_base);
            blbm_pkg::REG_THR_STEP:    prdata = 32'(r_cfg.threshold_step);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic r1_valid, r2_valid, r3_valid;
    logic w_adv1, w_adv2, w_adv3;
    logic w_accept;

    // A stage advances when it is empty or the stage after it advances.
    assign w_adv3        = !r3_valid || m_axis_tready;
    assign w_adv2        = !r2_valid || w_adv3;
    assign w_adv1        = !r1_valid || w_adv2;
    assign s_axis_tready = w_adv1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- stage 1: history update ----------------
    blbm_pkg::t_row             r_hist [NUM_BANDS];
    blbm_pkg::t_row             w_row_rd;
    blbm_pkg::t_row             w_row_new;
    logic [IDX_W-1:0]           w_idx;
    logic                       w_in_range;

    blbm_pkg::t_row             r1_row;
    logic [blbm_pkg::BAND_W-1:0] r1_band;

    assign w_idx      = IDX_W'(s_axis_tuser);
    assign w_in_range = (5'(s_axis_tuser) < NUM_BANDS_V);

    always_comb begin
        w_row_rd = w_in_range ? r_hist[w_idx] : '0;
        // Drop the oldest entry, append the reduced sample.
        for (int t = 0; t < blbm_pkg::HISTORY_TAPS - 1; t++) begin
            w_row_new[t] = w_row_rd[t+1];
        end
        w_row_new[blbm_pkg::HISTORY_TAPS-1] = s_axis_tdata[blbm_pkg::SAMPLE_W-1:2];
        // Out-of-range bands average to zero.
        if (!w_in_range) begin
            w_row_new = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_hist[b] <= '0;
            end
        end else if (w_accept && w_in_range) begin
            r_hist[w_idx] <= w_row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv1) begin
            r1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_row  <= w_row_new;
            r1_band <= s_axis_tuser;
        end
    end

    // ---------------- stage 2: four-tap mean ----------------
    logic [blbm_pkg::SUM_W-1:0]   w_sum;
    logic [blbm_pkg::LEVEL_W-1:0] r2_level;
    logic [blbm_pkg::BAND_W-1:0]  r2_band;

    always_comb begin
        w_sum = '0;
        for (int t = 0; t < blbm_pkg::HISTORY_TAPS; t++) begin
            w_sum = w_sum + blbm_pkg::SUM_W'(r1_row[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r1_valid) begin
            r2_level <= w_sum[blbm_pkg::SUM_W-1:blbm_pkg::TAP_SHIFT];
            r2_band  <= r1_band;
        end
    end

    // ---------------- stage 3: grade into the output register ----------------
    logic [blbm_pkg::COUNT_W-1:0]   w_count;
    logic [blbm_pkg::PATTERN_W-1:0] w_pattern;
    logic [blbm_pkg::LEVEL_W-1:0]   r3_level;
    logic [blbm_pkg::COUNT_W-1:0]   r3_count;
    logic [blbm_pkg::PATTERN_W-1:0] r3_pattern;
    logic [blbm_pkg::BAND_W-1:0]    r3_band;

    blbm_grader u_grader (
        .i_clk     (i_clk),
        .i_cfg     (r_cfg),
        .i_band    (r2_band),
        .i_level   (r2_level),
        .o_count   (w_count),
        .o_pattern (w_pattern)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r2_valid) begin
            r3_level   <= r2_level;
            r3_count   <= w_count;
            r3_pattern <= w_pattern;
            r3_band    <= r2_band;
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tuser  = r3_band;
    assign m_axis_tdata  = {7'd0, r3_pattern, r3_count, r3_level};

endmodule

// ----- hw/rtl/blbm_checker.sv -----
// Port-level checks of the band level bar meter and their bind.
module blbm_checker #(
    parameter int NUM_BANDS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [blbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [blbm_pkg::BAND_W-1:0]         m_axis_tuser
);

    // A stalled master beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("master beat changed under stall");

    // Lit bars in the pattern match the count.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[16:11]) == int'(m_axis_tdata[10:8])))
        else $error("bar pattern does not match bar count");

    // The unlit band shows no bars.
    a_unlit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == blbm_pkg::UNLIT_BAND) |->
            (m_axis_tdata[16:8] == '0))
        else $error("unlit band shows bars");

    // Unknown bands give an all-zero result.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (int'(m_axis_tuser) >= NUM_BANDS) |-> (m_axis_tdata == '0))
        else $error("out-of-range band gave nonzero result");

endmodule

bind band_level_bar_meter blbm_checker #(.NUM_BANDS(NUM_BANDS)) u_blbm_checker (.*);
